### sv/at_tok_pkg.sv
// shared types and constants for the at command line tokenizer
// no dependencies; imported by at_command_line_tokenizer_top and its testbench
package at_tok_pkg;

  localparam int LineBytes = 128;
  localparam int PosW      = 7;
  localparam int CountW    = 4;

  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharQuery = 8'h3F;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharPlus  = 8'h2B;

  localparam logic [7:0] HciCmd    = 8'h01;
  localparam logic [7:0] HciAcl    = 8'h02;
  localparam logic [7:0] HciVendA  = 8'h10;
  localparam logic [7:0] HciVendB  = 8'h20;

  typedef enum logic [1:0] {
    CmdPlain = 2'd0,
    CmdQuery = 2'd1,
    CmdSet   = 2'd2
  } cmd_type_t;

  typedef enum logic {
    KindHeader = 1'b0,
    KindParam  = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhHeld1 = 2'd1,
    PhHeld2 = 2'd2,
    PhLine  = 2'd3
  } phase_t;

endpackage

### sv/at_command_line_tokenizer_top.sv
// at command line tokenizer: byte stream in, line header and parameter items out
// depends on at_tok_pkg
//
// Takes one received byte per cycle when nothing is waiting. A byte is held in the
// input register, where it (and at most the two bytes held from the packet start) is parsed
// by a short chain of compares and 7-bit subtracts, and the line state is updated. A CR or
// LF that closes a line copies the line summary into the output stage, which then sends one
// header item and one item per parameter, one item per cycle while the receiver is ready:
// 1 + parameter_count items per line. Bytes keep flowing while those items go out; the input
// stalls only when a second line closes before all items of the previous line are taken.
module at_command_line_tokenizer_top #(
  parameter int MAX_PARAMS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // packet_start
  input  logic        s_axis_tlast,   // packet_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // command_type[1:0], name_length[8:2], parameter_count[12:9], parameter_number[16:13],
  // parameter_offset[23:17], parameter_length[30:24], too_many_parameters[31]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,   // item_kind
  output logic        m_axis_tlast    // last_item
);
  import at_tok_pkg::*;

  typedef struct packed {
    logic                               pending;
    logic [PosW-1:0]                    pos;
    logic [PosW-1:0]                    name_len;
    cmd_type_t                          ctype;
    logic [CountW-1:0]                  count;
    logic                               ovf;
    logic [MAX_PARAMS-1:0][PosW-1:0]    off;
    logic [MAX_PARAMS-1:0][PosW-1:0]    len;
  } line_t;

  typedef struct packed {
    line_t line;
    logic  emit;
  } step_t;

  function automatic step_t feed(step_t s, logic [7:0] b);
    step_t             r;
    logic [PosW-1:0]   p;
    logic [CountW-1:0] c;
    logic [CountW-1:0] c1;
    r  = s;
    p  = s.line.pos;
    c  = s.line.count;
    c1 = c + CountW'(1);
    if (s.line.pending) begin
      if (p >= PosW'(LineBytes - 1)) begin
        r.line.pending = 1'b0;
      end else begin
        r.line.pos = p + PosW'(1);
        if (b == CharCr || b == CharLf) begin
          if (s.line.ctype == CmdPlain) begin
            r.line.name_len = p - PosW'(3);
          end else if (s.line.ctype == CmdSet) begin
            for (int k = 0; k < MAX_PARAMS; k++) begin
              if (CountW'(k) == c) r.line.len[k] = p - s.line.off[k];
            end
          end
          r.line.pending = 1'b0;
          r.emit         = 1'b1;
        end else if (s.line.ctype == CmdPlain && b == CharEq) begin
          r.line.name_len = p - PosW'(3);
          r.line.ctype    = CmdSet;
          r.line.count    = '0;
          r.line.off[0]   = p + PosW'(1);
        end else if (s.line.ctype == CmdPlain && b == CharQuery) begin
          r.line.name_len = p - PosW'(3);
          r.line.ctype    = CmdQuery;
        end else if (s.line.ctype == CmdSet && b == CharComma) begin
          if (c1 < CountW'(MAX_PARAMS)) begin
            for (int k = 0; k < MAX_PARAMS; k++) begin
              if (CountW'(k) == c)  r.line.len[k] = p - s.line.off[k];
              if (CountW'(k) == c1) r.line.off[k] = p + PosW'(1);
            end
            r.line.count = c1;
          end else begin
            r.line.ovf = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;
  logic       in_end;
  logic       in_take;

  // parser state
  line_t      line;
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held0;
  logic [7:0] held1;
  logic [7:0] held0_next;
  logic [7:0] held1_next;
  step_t      stp;

  // output stage
  logic              busy;
  logic [CountW-1:0] idx;
  line_t             snap;
  logic [CountW-1:0] tot;
  logic              last_beat;
  logic              emit_free;
  logic              load;
  item_kind_t        kind;
  logic [CountW-1:0] pnum;
  logic [PosW-1:0]   poff;
  logic [PosW-1:0]   plen;

  // next state of the parser
  always_comb begin
    stp        = '{line: line, emit: 1'b0};
    phase_next = phase;
    held0_next = held0;
    held1_next = held1;
    if (in_start) begin
      if (in_byte == HciCmd || in_byte == HciAcl || in_byte == HciVendA ||
          in_byte == HciVendB) begin
        phase_next = PhIdle;
      end else begin
        held0_next = in_byte;
        phase_next = PhHeld1;
        if (in_end) stp = feed(stp, in_byte);
      end
    end else begin
      unique case (phase)
        PhHeld1: begin
          held1_next = in_byte;
          phase_next = PhHeld2;
          if (in_end) begin
            stp = feed(stp, held0);
            stp = feed(stp, in_byte);
          end
        end
        PhHeld2: begin
          if (held0 == CharA && held1 == CharT && in_byte == CharPlus) begin
            stp.line.pending  = 1'b1;
            stp.line.pos      = PosW'(3);
            stp.line.name_len = '0;
            stp.line.ctype    = CmdPlain;
            stp.line.count    = '0;
            stp.line.ovf      = 1'b0;
            phase_next        = PhLine;
          end else if (line.pending) begin
            stp        = feed(stp, held0);
            stp        = feed(stp, held1);
            stp        = feed(stp, in_byte);
            phase_next = stp.line.pending ? PhLine : PhIdle;
          end else begin
            phase_next = PhIdle;
          end
        end
        PhLine: begin
          stp = feed(stp, in_byte);
          if (!stp.line.pending) phase_next = PhIdle;
        end
        PhIdle: begin
        end
        default: begin
          phase_next = PhIdle;
        end
      endcase
    end
    if (in_end) phase_next = PhIdle;
  end

  assign tot       = (snap.ctype == CmdSet) ? snap.count + CountW'(1) : '0;
  assign last_beat = (idx == tot);
  assign emit_free = !busy || (m_axis_tready && last_beat);
  assign in_take   = in_full && (!stp.emit || emit_free);
  assign load      = in_take && stp.emit;
  assign s_axis_tready = !in_full || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (in_take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
      in_end   <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PhIdle;
      line.pending  <= 1'b0;
      line.pos      <= '0;
      line.name_len <= '0;
      line.ctype    <= CmdPlain;
      line.count    <= '0;
      line.ovf      <= 1'b0;
    end else if (in_take) begin
      phase <= phase_next;
      line  <= stp.line;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_axis_tready) begin
      if (last_beat) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) snap <= stp.line;
  end

  // outputs of the item sequencer
  always_comb begin
    kind = (idx == '0) ? KindHeader : KindParam;
    pnum = '0;
    poff = '0;
    plen = '0;
    for (int k = 0; k < MAX_PARAMS; k++) begin
      if (CountW'(k) + CountW'(1) == idx) begin
        pnum = CountW'(k);
        poff = snap.off[k];
        plen = snap.len[k];
      end
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tuser  = kind;
  assign m_axis_tlast  = last_beat;
  assign m_axis_tdata  = {snap.ovf, plen, poff, pnum, tot, snap.name_len, snap.ctype};

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= tot)
    else $error("item index past parameter total");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    line.count < CountW'(MAX_PARAMS))
    else $error("parameter count past limit");

  a_line_phase: assert property (@(posedge clk) disable iff (rst)
    phase == PhLine |-> line.pending)
    else $error("streaming phase without a pending line");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (busy && !(m_axis_tready && last_beat)) |-> !load)
    else $error("line summary loaded while previous items still going out");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (busy && m_axis_tready && last_beat && !load) |=> !busy)
    else $error("sequencer busy after final item taken");
`endif

endmodule

### verif/tb_at_command_line_tokenizer_top.sv
// testbench for at_command_line_tokenizer_top: a directed byte table, then random packet traffic
// every output item is checked against an in-bench line parser; needs at_tok_pkg and the top
`timescale 1ns / 100ps

module tb_at_command_line_tokenizer_top;
  import at_tok_pkg::*;

  localparam int MaxParams = 10;
  localparam int NumDir    = 25;
  localparam int RandBytes = 40;

  typedef struct packed {
    item_kind_t kind;
    cmd_type_t  ctype;
    logic [6:0] nlen;
    logic [3:0] pcnt;
    logic [3:0] pnum;
    logic [6:0] poff;
    logic [6:0] plen;
    logic       many;
    logic       last;
  } tok_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       fin;
    logic       chk;
    cmd_type_t  ctype;
    logic [6:0] nlen;
    logic [3:0] pcnt;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // line parser state
  logic       ln_pend;
  phase_t     phase;
  logic [7:0] hold [2];
  logic [1:0] hold_n;
  logic [6:0] pos;
  logic [6:0] nlen_r;
  cmd_type_t  ctype_r;
  logic [3:0] pcnt_r;
  logic [6:0] p_off [MaxParams];
  logic [6:0] p_len [MaxParams];
  logic       ovf;

  tok_item_t  items_due [$];
  tok_item_t  last_hdr;
  tok_item_t  got_due;
  logic [7:0] pkt_buf [$];
  int         lines_closed;
  int         errors;
  int         items_seen;
  int         bytes_sent;
  int         rand_sent;
  bit         calm;

  // short packets, hci drop, unterminated packets, query split over packets, empty parameter
  dir_row_t dir_tab [NumDir] = '{
    '{8'h00,    1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharA,    1'b1, 1'b1, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{HciCmd,   1'b1, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharT,    1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharPlus, 1'b0, 1'b1, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharA,    1'b1, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharT,    1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharPlus, 1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharCr,   1'b0, 1'b1, 1'b1, CmdPlain, 7'd0, 4'd0},
    '{CharA,    1'b1, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharT,    1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharPlus, 1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{8'h58,    1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharQuery, 1'b0, 1'b1, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{8'h5A,    1'b1, 1'b1, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharLf,   1'b1, 1'b1, 1'b1, CmdQuery, 7'd1, 4'd0},
    '{CharA,    1'b1, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharT,    1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharPlus, 1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharEq,   1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharComma, 1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{8'hFF,    1'b0, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharCr,   1'b0, 1'b1, 1'b1, CmdSet,   7'd0, 4'd2},
    '{CharA,    1'b1, 1'b0, 1'b0, CmdPlain, 7'd0, 4'd0},
    '{CharCr,   1'b1, 1'b1, 1'b0, CmdPlain, 7'd0, 4'd0}
  };

  at_command_line_tokenizer_top #(
    .MAX_PARAMS(MaxParams)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic void push_item(item_kind_t kind, int total, int num, int off, int len,
                                    bit last);
    tok_item_t it;
    it.kind  = kind;
    it.ctype = ctype_r;
    it.nlen  = nlen_r;
    it.pcnt  = 4'(total);
    it.pnum  = 4'(num);
    it.poff  = 7'(off);
    it.plen  = 7'(len);
    it.many  = ovf;
    it.last  = last;
    items_due.push_back(it);
    if (kind == KindHeader) begin
      last_hdr = it;
    end
  endfunction

  function automatic void close_line();
    int total;
    int k;
    total = (ctype_r == CmdSet) ? int'(pcnt_r) + 1 : 0;
    if (total > MaxParams) begin
      total = MaxParams;
    end
    push_item(KindHeader, total, 0, 0, 0, total == 0);
    for (k = 0; k < total; k++) begin
      push_item(KindParam, total, k, p_off[k], p_len[k], k + 1 == total);
    end
    lines_closed++;
  endfunction

  function automatic void line_byte(logic [7:0] b);
    int p;
    int c;
    if (!ln_pend) begin
      return;
    end
    p = pos;
    // line full: abandon without output
    if (p + 1 >= LineBytes) begin
      ln_pend = 1'b0;
      phase   = PhIdle;
      hold_n  = '0;
      return;
    end
    pos = 7'(p + 1);
    c = pcnt_r;
    if (c >= MaxParams) begin
      c = MaxParams - 1;
    end
    if (b == CharCr || b == CharLf) begin
      if (ctype_r == CmdPlain) begin
        nlen_r = 7'(p - 3);
      end else if (ctype_r == CmdSet) begin
        p_len[c] = 7'(p - int'(p_off[c]));
      end
      ln_pend = 1'b0;
      phase   = PhIdle;
      hold_n  = '0;
      close_line();
      return;
    end
    if (ctype_r == CmdPlain && b == CharEq) begin
      nlen_r   = 7'(p - 3);
      ctype_r  = CmdSet;
      pcnt_r   = '0;
      p_off[0] = 7'(p + 1);
      p_len[0] = '0;
    end else if (ctype_r == CmdPlain && b == CharQuery) begin
      nlen_r  = 7'(p - 3);
      ctype_r = CmdQuery;
    end else if (ctype_r == CmdSet && b == CharComma) begin
      if (c + 1 < MaxParams) begin
        p_len[c]     = 7'(p - int'(p_off[c]));
        pcnt_r       = 4'(c + 1);
        p_off[c + 1] = 7'(p + 1);
        p_len[c + 1] = '0;
      end else begin
        ovf = 1'b1;
      end
    end
  endfunction

  function automatic void flush_held();
    int i;
    for (i = 0; i < int'(hold_n) && i < 2; i++) begin
      line_byte(hold[i]);
    end
  endfunction

  function automatic void tok_step(logic [7:0] d, logic first, logic fin);
    if (first) begin
      hold_n = '0;
      if (d == HciCmd || d == HciAcl || d == HciVendA || d == HciVendB) begin
        phase = PhIdle;
      end else begin
        hold[0] = d;
        hold_n  = 2'd1;
        phase   = PhHeld1;
        if (fin) begin
          flush_held();
        end
      end
    end else if (phase == PhHeld1) begin
      hold[1] = d;
      hold_n  = 2'd2;
      phase   = PhHeld2;
      if (fin) begin
        flush_held();
      end
    end else if (phase == PhHeld2) begin
      if (hold[0] == CharA && hold[1] == CharT && d == CharPlus) begin
        ln_pend = 1'b1;
        pos     = 7'd3;
        nlen_r  = '0;
        ctype_r = CmdPlain;
        pcnt_r  = '0;
        ovf     = 1'b0;
        phase   = PhLine;
      end else if (ln_pend) begin
        flush_held();
        line_byte(d);
        phase = ln_pend ? PhLine : PhIdle;
      end else begin
        phase = PhIdle;
      end
      hold_n = '0;
    end else if (phase == PhLine) begin
      line_byte(d);
      if (!ln_pend) begin
        phase = PhIdle;
      end
    end
    if (fin) begin
      phase  = PhIdle;
      hold_n = '0;
    end
  endfunction

  function automatic void cmp_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      errors++;
    end
  endfunction

  task automatic send_byte(logic [7:0] d, logic first, logic fin);
    while (!calm && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= first;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    tok_step(d, first, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sends pkt_buf as one packet, or cut into several
  task automatic send_buf(bit whole);
    int i;
    int j;
    int cut;
    i = 0;
    while (i < pkt_buf.size()) begin
      if (whole || $urandom_range(0, 99) < 70) begin
        cut = pkt_buf.size();
      end else begin
        cut = i + int'($urandom_range(1, pkt_buf.size() - i));
      end
      for (j = i; j < cut; j++) begin
        send_byte(pkt_buf[j], j == i, j == cut - 1);
        rand_sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      i = cut;
    end
  endtask

  task automatic build_line(int name_n, int form, int commas, bit closed);
    int i;
    pkt_buf = {};
    pkt_buf.push_back(CharA);
    pkt_buf.push_back(CharT);
    pkt_buf.push_back(CharPlus);
    for (i = 0; i < name_n; i++) begin
      pkt_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
    end
    if (form == 1) begin
      pkt_buf.push_back(CharQuery);
      repeat ($urandom_range(0, 3)) pkt_buf.push_back(8'($urandom_range(8'h2C, 8'h7E)));
    end else if (form == 2) begin
      pkt_buf.push_back(CharEq);
      for (i = 0; i <= commas; i++) begin
        repeat ($urandom_range(0, 3)) pkt_buf.push_back(8'($urandom_range(8'h30, 8'h7E)));
        if (i < commas) begin
          pkt_buf.push_back(CharComma);
        end
      end
    end
    if (closed) begin
      pkt_buf.push_back($urandom_range(0, 1) ? CharCr : CharLf);
      // bytes after the terminator are dropped
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) pkt_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_noise();
    logic [7:0] hci_codes [4];
    logic [7:0] d;
    int         n;
    int         i;
    hci_codes = '{HciCmd, HciAcl, HciVendA, HciVendB};
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      d = 8'($urandom_range(0, 255));
      if (i == 0 && $urandom_range(0, 9) < 3) begin
        d = hci_codes[$urandom_range(0, 3)];
      end
      send_byte(d, (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0),
                (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0));
      rand_sent++;
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (items_due.size() == 0) begin
        $error("output item with nothing expected: data %h kind %0d last %0d",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        got_due = items_due.pop_front();
        cmp_field("item_kind", got_due.kind, m_axis_tuser);
        cmp_field("command_type", got_due.ctype, m_axis_tdata[1:0]);
        cmp_field("name_length", got_due.nlen, m_axis_tdata[8:2]);
        cmp_field("parameter_count", got_due.pcnt, m_axis_tdata[12:9]);
        cmp_field("parameter_number", got_due.pnum, m_axis_tdata[16:13]);
        cmp_field("parameter_offset", got_due.poff, m_axis_tdata[23:17]);
        cmp_field("parameter_length", got_due.plen, m_axis_tdata[30:24]);
        cmp_field("too_many_parameters", got_due.many, m_axis_tdata[31]);
        cmp_field("last_item", got_due.last, m_axis_tlast);
      end
      items_seen++;
    end
  end

  initial begin
    int r;
    int n0;
    int pick;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    ln_pend       = 1'b0;
    phase         = PhIdle;
    hold          = '{8'h00, 8'h00};
    hold_n        = '0;
    pos           = '0;
    nlen_r        = '0;
    ctype_r       = CmdPlain;
    pcnt_r        = '0;
    ovf           = 1'b0;
    for (r = 0; r < MaxParams; r++) begin
      p_off[r] = '0;
      p_len[r] = '0;
    end
    lines_closed  = 0;
    errors        = 0;
    items_seen    = 0;
    bytes_sent    = 0;
    rand_sent     = 0;
    calm          = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < NumDir; r++) begin
      n0 = lines_closed;
      send_byte(dir_tab[r].data, dir_tab[r].first, dir_tab[r].fin);
      if (dir_tab[r].chk && (lines_closed != n0 + 1 || last_hdr.ctype != dir_tab[r].ctype ||
          last_hdr.nlen != dir_tab[r].nlen || last_hdr.pcnt != dir_tab[r].pcnt)) begin
        $error("row %0d: header type %0d name %0d count %0d, table has %0d %0d %0d", r,
               last_hdr.ctype, last_hdr.nlen, last_hdr.pcnt, dir_tab[r].ctype,
               dir_tab[r].nlen, dir_tab[r].pcnt);
        errors++;
      end
    end

    // name one byte too long for the line, sent with no idling on either side
    calm = 1'b1;
    build_line(124, 0, 0, 1'b1);
    send_buf(1'b1);
    calm = 1'b0;
    // too many commas
    build_line(2, 2, 13, 1'b1);
    send_buf(1'b1);

    rand_sent = 0;
    while (rand_sent < RandBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_line($urandom_range(0, 6), $urandom_range(0, 2),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 3),
                   1'b1);
        send_buf(1'b0);
      end else if (pick < 75) begin
        build_line($urandom_range(0, 6), $urandom_range(0, 2), $urandom_range(0, 3), 1'b0);
        repeat ($urandom_range(0, 3)) begin
          if (pkt_buf.size() > 1) begin
            void'(pkt_buf.pop_back());
          end
        end
        send_buf(1'b0);
      end else if (pick < 85) begin
        pkt_buf = {};
        repeat ($urandom_range(1, 4)) pkt_buf.push_back(8'($urandom_range(8'h2C, 8'h7E)));
        if ($urandom_range(0, 9) < 4) begin
          pkt_buf.push_back($urandom_range(0, 1) ? CharCr : CharLf);
        end
        send_buf(1'b0);
      end else begin
        send_noise();
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (items_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("bytes sent %0d, output items checked %0d, lines closed %0d", bytes_sent,
             items_seen, lines_closed);
    $display("covered split, short, hci and unterminated packets, line overflow, comma overflow");
    if (errors == 0 && items_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
